[hdl/cht_pkg.sv]
// Shared types and constants for the two-table cuckoo hash store.
// No dependencies; used by two_table_cuckoo_hash.
`default_nettype none

package cht_pkg;

  localparam int KEY_W         = 31;
  localparam int FUNC_W        = 2;
  localparam int SLOT_W        = 10;
  localparam int SLOTS_DEFAULT = 16;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 16;

  // reciprocal hashing: q = (key * magic) >> shift, exact for any 31-bit key
  localparam int MAGIC_W = 32;
  localparam int PROD_W  = KEY_W + MAGIC_W;
  localparam int DEC_W   = 4;
  localparam int DEC_SHIFT = KEY_W + DEC_W;
  localparam logic [MAGIC_W-1:0] DEC_MAGIC = 32'hCCCC_CCCD;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SEARCH = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_DELETE = 2'd2
  } func_e;

  typedef struct packed {
    logic             tomb;
    logic             used;
    logic [KEY_W-1:0] key;
  } first_entry_t;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
  } second_entry_t;

endpackage

`default_nettype wire

[hdl/two_table_cuckoo_hash.sv]
// A search, delete or free-slot insert passes through hash multiply, remainder, memory read and
// update; an insert that finds its first-table slot used rehashes the displaced occupant through
// the same steps. A new item is taken only in idle, after the previous update, and the update waits
// for the previous result transfer. Reset: asynchronous, active low; a clearing pass then empties
// both tables while s_axis_tready stays low. Depends on cht_pkg.
`default_nettype none

module two_table_cuckoo_hash #(
  parameter int SLOTS = cht_pkg::SLOTS_DEFAULT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [1:0] func, [32:2] key, [39:33] zero
  input  wire logic [cht_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [0] found, [1] in_second_table, [11:2] slot, [12] dropped, [15:13] zero
  output logic [cht_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

  localparam int SW = $clog2(SLOTS);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
  localparam int HOME_SHIFT = cht_pkg::KEY_W + SW;
  localparam logic [cht_pkg::MAGIC_W-1:0] HOME_MAGIC =
    cht_pkg::MAGIC_W'(((64'd1 << HOME_SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));
  localparam logic [SW-1:0] SLOTS_LO = SW'(SLOTS);
  localparam logic [cht_pkg::DEC_W-1:0] TEN_LO = cht_pkg::DEC_W'(10);

  // second hash by key mod 10: digit = (9*r) mod 10, slot = SLOTS*digit/10
  localparam logic [SW-1:0] H2_1 = SW'((SLOTS * 1) / 10);
  localparam logic [SW-1:0] H2_2 = SW'((SLOTS * 2) / 10);
  localparam logic [SW-1:0] H2_3 = SW'((SLOTS * 3) / 10);
  localparam logic [SW-1:0] H2_4 = SW'((SLOTS * 4) / 10);
  localparam logic [SW-1:0] H2_5 = SW'((SLOTS * 5) / 10);
  localparam logic [SW-1:0] H2_6 = SW'((SLOTS * 6) / 10);
  localparam logic [SW-1:0] H2_7 = SW'((SLOTS * 7) / 10);
  localparam logic [SW-1:0] H2_8 = SW'((SLOTS * 8) / 10);
  localparam logic [SW-1:0] H2_9 = SW'((SLOTS * 9) / 10);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_RD,
    ST_EV
  } state_e;

  function automatic logic [SW-1:0] hash_two(input logic [cht_pkg::DEC_W-1:0] r);
    logic [SW-1:0] h;
    case (r)
      4'd1:    h = H2_9;
      4'd2:    h = H2_8;
      4'd3:    h = H2_7;
      4'd4:    h = H2_6;
      4'd5:    h = H2_5;
      4'd6:    h = H2_4;
      4'd7:    h = H2_3;
      4'd8:    h = H2_2;
      4'd9:    h = H2_1;
      default: h = '0;
    endcase
    return h;
  endfunction

  state_e                       state_q, state_d;
  logic [SW-1:0]                clr_q, clr_d;
  logic [cht_pkg::KEY_W-1:0]    hk_q, hk_d;
  logic [SW-1:0]                qs_q, qs_d;
  logic [cht_pkg::DEC_W-1:0]    qt_q, qt_d;
  logic [SW-1:0]                ha_q, ha_d;
  logic [SW-1:0]                hb_q, hb_d;
  cht_pkg::func_e               func_q, func_d;
  logic [cht_pkg::KEY_W-1:0]    key_q, key_d;
  logic                         occ_q, occ_d;
  logic                         mv_q, mv_d;
  logic                         found_q, found_d;
  logic                         sec_q, sec_d;
  logic [cht_pkg::SLOT_W-1:0]   slot_q, slot_d;
  logic                         drop_q, drop_d;

  cht_pkg::first_entry_t        mem1 [SLOTS];
  cht_pkg::second_entry_t       mem2 [SLOTS];
  cht_pkg::first_entry_t        rd1_q, w1_data;
  cht_pkg::second_entry_t       rd2_q, w2_data;
  logic                         w1_en, w2_en;
  logic [SW-1:0]                w1_addr, w2_addr;

  logic [cht_pkg::PROD_W-1:0]   prod_h, prod_t;
  logic [SW-1:0]                qs_nx, rs_mod;
  logic [cht_pkg::DEC_W-1:0]    qt_nx, rt_mod;
  logic                         stop1, hit1, hit2, done;

  // only the low quotient bits are kept: each remainder fits in them
  assign prod_h = cht_pkg::PROD_W'(hk_q) * cht_pkg::PROD_W'(HOME_MAGIC);
  assign prod_t = cht_pkg::PROD_W'(hk_q) * cht_pkg::PROD_W'(cht_pkg::DEC_MAGIC);
  assign qs_nx  = prod_h[HOME_SHIFT +: SW];
  assign qt_nx  = prod_t[cht_pkg::DEC_SHIFT +: cht_pkg::DEC_W];
  assign rs_mod = hk_q[SW-1:0] - qs_q * SLOTS_LO;
  assign rt_mod = hk_q[cht_pkg::DEC_W-1:0] - qt_q * TEN_LO;

  assign stop1 = !rd1_q.used && !rd1_q.tomb;
  assign hit1  = rd1_q.used && (rd1_q.key == key_q);
  assign hit2  = !stop1 && rd2_q.used && (rd2_q.key == key_q);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    hk_d    = hk_q;
    qs_d    = qs_q;
    qt_d    = qt_q;
    ha_d    = ha_q;
    hb_d    = hb_q;
    func_d  = func_q;
    key_d   = key_q;
    occ_d   = occ_q;
    mv_d    = mv_q && !m_axis_tready;
    found_d = found_q;
    sec_d   = sec_q;
    slot_d  = slot_q;
    drop_d  = drop_q;
    w1_en   = 1'b0;
    w1_addr = ha_q;
    w1_data = '0;
    w2_en   = 1'b0;
    w2_addr = hb_q;
    w2_data = '0;
    done    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        w1_en   = 1'b1;
        w1_addr = clr_q;
        w2_en   = 1'b1;
        w2_addr = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == LAST_SLOT) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          func_d  = cht_pkg::func_e'(s_axis_tdata[cht_pkg::FUNC_W-1:0]);
          key_d   = s_axis_tdata[cht_pkg::FUNC_W +: cht_pkg::KEY_W];
          hk_d    = s_axis_tdata[cht_pkg::FUNC_W +: cht_pkg::KEY_W];
          occ_d   = 1'b0;
          state_d = ST_HASH;
        end
      end
      ST_HASH: begin
        qs_d    = qs_nx;
        qt_d    = qt_nx;
        state_d = ST_MOD;
      end
      ST_MOD: begin
        if (!occ_q) ha_d = rs_mod;
        hb_d    = hash_two(rt_mod);
        state_d = ST_RD;
      end
      ST_RD: begin
        state_d = ST_EV;
      end
      ST_EV: begin
        if (!mv_q || m_axis_tready) begin
          done    = 1'b1;
          found_d = 1'b0;
          sec_d   = 1'b0;
          slot_d  = '0;
          drop_d  = 1'b0;
          case (func_q)
            cht_pkg::FUNC_SEARCH, cht_pkg::FUNC_DELETE: begin
              if (hit1) begin
                found_d = 1'b1;
                slot_d  = cht_pkg::SLOT_W'(ha_q);
                if (func_q == cht_pkg::FUNC_DELETE) begin
                  w1_en        = 1'b1;
                  w1_data.tomb = 1'b1;
                end
              end else if (hit2) begin
                found_d = 1'b1;
                sec_d   = 1'b1;
                slot_d  = cht_pkg::SLOT_W'(hb_q);
                if (func_q == cht_pkg::FUNC_DELETE) w2_en = 1'b1;
              end
            end
            cht_pkg::FUNC_INSERT: begin
              if (!occ_q) begin
                if (!rd1_q.used) begin
                  w1_en        = 1'b1;
                  w1_data.used = 1'b1;
                  w1_data.key  = key_q;
                end else begin
                  // displace: rehash the occupant
                  done    = 1'b0;
                  hk_d    = rd1_q.key;
                  occ_d   = 1'b1;
                  state_d = ST_HASH;
                end
              end else if (!rd2_q.used) begin
                w2_en        = 1'b1;
                w2_data.used = 1'b1;
                w2_data.key  = rd1_q.key;
                w1_en        = 1'b1;
                w1_data      = rd1_q;
                w1_data.key  = key_q;
              end else begin
                drop_d = 1'b1;
              end
            end
            default: ;
          endcase
          if (done) begin
            mv_d    = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      occ_q   <= 1'b0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      occ_q   <= occ_d;
      mv_q    <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hk_q    <= hk_d;
    qs_q    <= qs_d;
    qt_q    <= qt_d;
    ha_q    <= ha_d;
    hb_q    <= hb_d;
    func_q  <= func_d;
    key_q   <= key_d;
    found_q <= found_d;
    sec_q   <= sec_d;
    slot_q  <= slot_d;
    drop_q  <= drop_d;
  end

  always_ff @(posedge clk_i) begin
    if (w1_en) mem1[w1_addr] <= w1_data;
    rd1_q <= mem1[ha_q];
  end

  always_ff @(posedge clk_i) begin
    if (w2_en) mem2[w2_addr] <= w2_data;
    rd2_q <= mem2[hb_q];
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = cht_pkg::M_TDATA_W'({drop_q, slot_q, sec_q, found_q});

  a_accept_starts_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == ST_HASH))
    else $error("accepted item did not start the hash");

  a_result_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == ST_EV))
    else $error("result raised outside the update cycle");

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !m_axis_tvalid)
    else $error("result during clearing pass");

  a_read_after_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |-> ($past(state_q) == ST_MOD))
    else $error("memory read without a finished hash");

  a_drop_excludes_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(found_q && drop_q))
    else $error("result both found and dropped");

endmodule

`default_nettype wire
